>>> design/swpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpi_pkg
// Shared types and codes for the stack with positional insert: request and
// result payloads, command and error codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package swpi_pkg;

    // Command codes carried in a request
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_INSERT = 2'd2
    } cmd_code_t;

    // Error codes carried in a result
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_POS   = 2'd3
    } err_code_t;

    // Request payload
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_byte;
        logic [8:0] position;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] error;
        logic [8:0] count;
        logic       is_empty;
    } out_item_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted request
        logic exec;     // check and run push, pop, or start an insert
        logic shift;    // move one entry up during an insert
        logic load;     // load the result register
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic start_shift; // insert passed its checks, entries must move
        logic shift_done;  // insert byte written, fill updated
        logic out_free;    // result register can take a new result
    } stat_t;

endpackage

>>> design/swpi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpi_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
module swpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/swpi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpi_ctrl
// Controller for the stack: takes one request at a time, sequences the
// execute, entry shift and result load steps of the datapath.
// ----------------------------------------------------------------------------
module swpi_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  swpi_pkg::stat_t stat,
    output swpi_pkg::ctl_t  ctl
);
    import swpi_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = stat.start_shift ? ST_SHIFT : ST_DONE;
            end
            ST_SHIFT: begin
                if (stat.shift_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready     = 1'b0;
        ctl         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                ctl.capture = s_valid;
            end
            ST_EXEC: begin
                ctl.exec = 1'b1;
            end
            ST_SHIFT: begin
                ctl.shift = 1'b1;
            end
            ST_DONE: begin
                ctl.load = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/swpi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpi_dp
// Datapath for the stack: request register, fill count, entry memory,
// insert shift pointer and the result register.
// ----------------------------------------------------------------------------
module swpi_dp #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  swpi_pkg::in_item_t  s_data,
    input  swpi_pkg::ctl_t      ctl,
    output swpi_pkg::stat_t     stat,
    output logic                m_valid,
    input  logic                m_ready,
    output swpi_pkg::out_item_t m_data
);
    import swpi_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > 9) ? FW : 9;

    // Request and control registers
    in_item_t        req_reg;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic [FW-1:0]   ptr_reg;
    logic [FW-1:0]   ptr_next;
    logic            mv_valid_reg;
    logic            mv_valid_next;
    logic [AW-1:0]   mv_addr_reg;
    logic [AW-1:0]   mv_addr_next;
    logic [1:0]      err_reg;
    logic [1:0]      err_next;
    logic            popped_reg;
    logic            popped_next;
    logic            m_valid_reg;
    out_item_t       m_data_reg;

    // Memory port signals
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;

    // Checks and helpers
    logic            full;
    logic            empty;
    logic            pos_bad;
    logic            ptr_above;
    logic            ptr_at;
    logic            insert_ok;
    logic [FW-1:0]   fill_dec;
    logic [FW-1:0]   ptr_dec;

    assign full      = (fill_reg == FW'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign pos_bad   = (CW'(req_reg.position) > CW'(fill_reg));
    assign ptr_above = (CW'(ptr_reg) > CW'(req_reg.position));
    assign ptr_at    = (CW'(ptr_reg) == CW'(req_reg.position));
    assign fill_dec  = fill_reg - FW'(1);
    assign ptr_dec   = ptr_reg - FW'(1);
    assign insert_ok = (req_reg.cmd == CMD_INSERT) && !full && !pos_bad;

    // Run the command, step the insert shift
    always_comb begin
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        mv_valid_next = mv_valid_reg;
        mv_addr_next  = mv_addr_reg;
        err_next      = err_reg;
        popped_next   = popped_reg;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[AW-1:0];
        wr_data       = req_reg.in_byte;
        rd_en         = 1'b0;
        rd_addr       = fill_dec[AW-1:0];
        stat.start_shift = 1'b0;
        stat.shift_done  = 1'b0;
        stat.out_free    = !m_valid_reg || m_ready;

        if (ctl.exec) begin
            err_next    = ERR_OK;
            popped_next = 1'b0;
            case (req_reg.cmd)
                CMD_PUSH: begin
                    if (full) begin
                        err_next = ERR_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                end
                CMD_POP: begin
                    if (empty) begin
                        err_next = ERR_EMPTY;
                    end else begin
                        rd_en       = 1'b1;
                        popped_next = 1'b1;
                        fill_next   = fill_dec;
                    end
                end
                CMD_INSERT: begin
                    if (full) begin
                        err_next = ERR_FULL;
                    end else if (pos_bad) begin
                        err_next = ERR_POS;
                    end
                end
                default: begin
                    err_next = ERR_OK;
                end
            endcase
            if (insert_ok) begin
                stat.start_shift = 1'b1;
                ptr_next         = fill_reg;
                mv_valid_next    = 1'b0;
            end
        end

        if (ctl.shift) begin
            // Write back the entry read last cycle one place higher
            if (mv_valid_reg) begin
                wr_en   = 1'b1;
                wr_addr = mv_addr_reg;
                wr_data = rd_data;
            end else if (ptr_at) begin
                wr_en           = 1'b1;
                wr_addr         = ptr_reg[AW-1:0];
                wr_data         = req_reg.in_byte;
                fill_next       = fill_reg + FW'(1);
                stat.shift_done = 1'b1;
            end
            // Read the next entry below the pointer
            if (ptr_above) begin
                rd_en         = 1'b1;
                rd_addr       = ptr_dec[AW-1:0];
                mv_addr_next  = ptr_reg[AW-1:0];
                mv_valid_next = 1'b1;
                ptr_next      = ptr_dec;
            end else begin
                mv_valid_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            mv_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            mv_valid_reg <= mv_valid_next;
            if (ctl.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            req_reg <= s_data;
        end
        ptr_reg     <= ptr_next;
        mv_addr_reg <= mv_addr_next;
        err_reg     <= err_next;
        popped_reg  <= popped_next;
        if (ctl.load) begin
            m_data_reg.out_byte <= popped_reg ? rd_data : 8'd0;
            m_data_reg.error    <= err_reg;
            m_data_reg.count    <= 9'(fill_reg);
            m_data_reg.is_empty <= empty;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Entry storage
    swpi_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

>>> design/stack_with_positional_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_positional_insert
// Bounded LIFO stack of bytes with push, pop and insert at a position.
//
// Each request on s_ (valid/ready) carries a command, a byte and a position;
// each yields exactly one result on m_ (valid/ready) with the popped byte, an
// error code, the new count and an empty flag.
// Push, pop, an unused code and any rejected command run in the execute step
// and then wait for the result load; the next request is taken after the
// result is loaded.
// Insert at position p with count n moves n - p entries, one per cycle through
// the single write port of the entry memory, then writes the last moved entry
// and then the insert byte before the result is loaded. With p equal to n only
// the insert byte is written.
// Reset clears the count and the result valid flag; entry memory is not
// cleared and needs no clearing pass. s_ready is high whenever no request is
// in work, also while a loaded result waits in the result register; when the
// receiver stalls, a finished result is held until the register frees up.
// ----------------------------------------------------------------------------
module stack_with_positional_insert #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swpi_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output swpi_pkg::out_item_t m_data
);
    import swpi_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    // Sequencer
    swpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // Stack storage and result path
    swpi_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctl     (ctl),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
